[rtl/fpa_pkg.sv]
// Shared types, codes and control store for the fixed partition allocator.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

  localparam int FPA_PARTITIONS = 16;
  localparam logic [15:0] FPA_MAX_PID = 16'd255;
  localparam int FPA_ADDR_W = 3;
  localparam logic FPA_REG_FIT_POLICY = 1'b0;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_NO_ID = 2'd2;

  localparam logic FIT_FIRST = 1'b0;

  localparam logic [2:0] U_FETCH = 3'd0;
  localparam logic [2:0] U_LOAD = 3'd1;
  localparam logic [2:0] U_SCAN = 3'd2;
  localparam logic [2:0] U_COMMIT = 3'd3;
  localparam logic [2:0] U_EMIT = 3'd4;

  localparam logic [1:0] C_ALWAYS = 2'd0;
  localparam logic [1:0] C_IN = 2'd1;
  localparam logic [1:0] C_SCAN = 2'd2;
  localparam logic [1:0] C_OUT = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  partition_index;
    logic [15:0] request_size;
    logic [7:0]  process_id;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  chosen_partition;
    logic [15:0] leftover;
    logic [23:0] fragmentation_total;
  } out_t;

  typedef struct packed {
    logic [1:0] cond;
    logic [2:0] target;
    logic       latch;
    logic       scan;
    logic       load_wr;
    logic       commit;
    logic       emit;
  } ucw_t;

  typedef struct packed {
    logic       in_valid;
    logic       scan_done;
    logic       out_free;
    logic [2:0] disp;
  } useq_flags_t;

  typedef struct packed {
    logic load;
    logic alloc;
    logic rel;
  } tbl_wr_t;

  function automatic ucw_t ucode_rom(input logic [2:0] step);
    ucw_t w;
    w = '0;
    unique case (step)
      U_FETCH: begin
        w.cond = C_IN;
        w.latch = 1'b1;
      end
      U_LOAD: begin
        w.cond = C_ALWAYS;
        w.target = U_EMIT;
        w.load_wr = 1'b1;
      end
      U_SCAN: begin
        w.cond = C_SCAN;
        w.target = U_COMMIT;
        w.scan = 1'b1;
      end
      U_COMMIT: begin
        w.cond = C_ALWAYS;
        w.target = U_EMIT;
        w.commit = 1'b1;
      end
      U_EMIT: begin
        w.cond = C_OUT;
        w.target = U_FETCH;
        w.emit = 1'b1;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.target = U_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[rtl/fpa_table.sv]
// Partition table: size and owner memories with busy and loaded flags.
`timescale 1ns / 1ps
`default_nettype none
module fpa_table #(
  parameter int PARTITIONS = fpa_pkg::FPA_PARTITIONS,
  localparam int IW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    rd_en,
  input  wire logic [IW-1:0]           rd_addr,
  output logic      [15:0]             rd_size,
  output logic      [7:0]              rd_owner,
  output logic                         rd_busy,
  input  wire fpa_pkg::tbl_wr_t        wr,
  input  wire logic [IW-1:0]           wr_addr,
  input  wire logic [15:0]             wr_size,
  input  wire logic [7:0]              wr_owner
);
  logic [15:0] size_mem [PARTITIONS];
  logic [7:0]  owner_mem [PARTITIONS];
  logic [PARTITIONS-1:0] busy_r, busy_nxt, loaded_r, loaded_nxt;
  logic [15:0] size_q_r;
  logic [7:0]  owner_q_r;
  logic        busy_q_r, loaded_q_r;

  always_ff @(posedge clk) begin
    if (wr.load) begin
      size_mem[wr_addr] <= wr_size;
    end
    if (wr.alloc) begin
      owner_mem[wr_addr] <= wr_owner;
    end
    if (rd_en) begin
      size_q_r <= size_mem[rd_addr];
      owner_q_r <= owner_mem[rd_addr];
      busy_q_r <= busy_r[rd_addr];
      loaded_q_r <= loaded_r[rd_addr];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    loaded_nxt = loaded_r;
    if (wr.load) begin
      busy_nxt[wr_addr] = 1'b0;
      loaded_nxt[wr_addr] = 1'b1;
    end
    if (wr.alloc) begin
      busy_nxt[wr_addr] = 1'b1;
    end
    if (wr.rel) begin
      busy_nxt[wr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      loaded_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      loaded_r <= loaded_nxt;
    end
  end

  // A partition that was never loaded has size zero.
  assign rd_size = loaded_q_r ? size_q_r : '0;
  assign rd_owner = owner_q_r;
  assign rd_busy = busy_q_r;

endmodule
`default_nettype wire

[rtl/fpa_useq.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
`timescale 1ns / 1ps
`default_nettype none
module fpa_useq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire fpa_pkg::useq_flags_t  flags,
  output fpa_pkg::ucw_t              ucw
);
  logic [2:0] pc_r, pc_nxt;

  assign ucw = fpa_pkg::ucode_rom(pc_r);

  always_comb begin
    pc_nxt = pc_r;
    unique case (ucw.cond)
      fpa_pkg::C_ALWAYS: pc_nxt = ucw.target;
      fpa_pkg::C_IN: if (flags.in_valid) begin
        pc_nxt = flags.disp;
      end
      fpa_pkg::C_SCAN: if (flags.scan_done) begin
        pc_nxt = ucw.target;
      end
      fpa_pkg::C_OUT: if (flags.out_free) begin
        pc_nxt = ucw.target;
      end
      default: pc_nxt = fpa_pkg::U_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= fpa_pkg::U_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/fixed_partition_allocator_core.sv]
// Fixed partition allocator top level: datapath, register port and result register.
// Requests arrive on in_valid/in_ready with one in_t payload each: load a
// partition size, allocate a partition to a process id, or release the
// partition a process id owns. Every request produces exactly one result on
// out_valid/out_ready, in request order.
// A load writes the partition size in its load step and then emits its
// result; an unused operation code or an invalid process id goes straight
// to the emit step. An allocate or a release walks the partition table one
// entry per cycle through the single read port of the table memory, then
// commits in a separate step and emits its result; the walk ends early
// when first fit or a release finds its entry.
// The fit policy register sits at byte address 0 of the APB port.
// Reset clears all partitions to free with size zero, clears the
// fragmentation total and selects first fit; no clearing pass is needed.
// A result waits in the output register while the receiver stalls, and the
// next request is still accepted; the block holds in its final step only
// while that register is occupied.
`timescale 1ns / 1ps
`default_nettype none
module fixed_partition_allocator_core #(
  parameter int PARTITIONS = fpa_pkg::FPA_PARTITIONS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fpa_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fpa_pkg::out_t                      out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fpa_pkg::FPA_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  localparam int IW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CW = $clog2(PARTITIONS + 1);

  fpa_pkg::ucw_t        ucw;
  fpa_pkg::useq_flags_t flags;
  fpa_pkg::tbl_wr_t     tbl_wr;
  fpa_pkg::in_t         req_r;
  fpa_pkg::out_t        out_data_r;

  logic          fit_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] pick_r, pick_nxt;
  logic [15:0]   best_r, best_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [3:0]    chosen_r, chosen_nxt;
  logic [15:0]   left_r, left_nxt;
  logic [23:0]   frag_r, frag_nxt;
  logic          out_valid_r;

  logic [15:0] rd_size;
  logic [7:0]  rd_owner;
  logic        rd_busy;
  logic        rd_en;
  logic [IW-1:0] wr_addr;

  logic [8:0]  req_idx9, pick9;
  logic        in_pid_ok, in_scan_op, is_rel, fit, better, match, take, hit;
  logic        accept, emit_fire;
  logic [15:0] gap;
  logic [24:0] sum25;

  assign pready = 1'b1;
  assign prdata = (paddr[fpa_pkg::FPA_ADDR_W-1:2] == fpa_pkg::FPA_REG_FIT_POLICY) ?
                  {31'b0, fit_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r <= fpa_pkg::FIT_FIRST;
    end else if (psel && penable && pwrite &&
                 paddr[fpa_pkg::FPA_ADDR_W-1:2] == fpa_pkg::FPA_REG_FIT_POLICY) begin
      fit_r <= pwdata[0];
    end
  end

  fpa_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ucw   (ucw)
  );

  assign in_ready = ucw.latch;
  assign accept = ucw.latch && in_valid;
  assign emit_fire = ucw.emit && (!out_valid_r || out_ready);

  assign req_idx9 = 9'(req_r.partition_index);
  assign pick9 = 9'(pick_r);
  assign in_pid_ok = (in_data.process_id != 8'd0) &&
                     (16'(in_data.process_id) <= fpa_pkg::FPA_MAX_PID);
  assign in_scan_op = (in_data.operation == fpa_pkg::OP_ALLOC) ||
                      (in_data.operation == fpa_pkg::OP_RELEASE);

  always_comb begin
    flags = '0;
    flags.in_valid = in_valid;
    flags.out_free = !out_valid_r || out_ready;
    flags.scan_done = hit || (!pend_r && cnt_r == CW'(PARTITIONS));
    if (in_data.operation == fpa_pkg::OP_LOAD) begin
      flags.disp = fpa_pkg::U_LOAD;
    end else if (in_scan_op && in_pid_ok) begin
      flags.disp = fpa_pkg::U_SCAN;
    end else begin
      flags.disp = fpa_pkg::U_EMIT;
    end
  end

  assign is_rel = (req_r.operation == fpa_pkg::OP_RELEASE);
  assign fit = pend_r && !rd_busy && (rd_size >= req_r.request_size);
  assign better = !found_r || (rd_size < best_r);
  assign match = pend_r && rd_busy && (rd_owner == req_r.process_id);
  assign take = is_rel ? (match && !found_r) : (fit && better);
  assign hit = is_rel ? match : (fit && fit_r == fpa_pkg::FIT_FIRST);
  assign rd_en = ucw.scan && (cnt_r < CW'(PARTITIONS));

  assign gap = best_r - req_r.request_size;
  assign sum25 = {1'b0, frag_r} + 25'(gap);

  always_comb begin
    cnt_nxt = cnt_r;
    pend_nxt = pend_r;
    pend_idx_nxt = pend_idx_r;
    found_nxt = found_r;
    pick_nxt = pick_r;
    best_nxt = best_r;
    status_nxt = status_r;
    chosen_nxt = chosen_r;
    left_nxt = left_r;
    frag_nxt = frag_r;
    tbl_wr = '0;
    wr_addr = pick_r;
    if (accept) begin
      cnt_nxt = '0;
      pend_nxt = 1'b0;
      found_nxt = 1'b0;
      left_nxt = '0;
      status_nxt = (in_scan_op && !in_pid_ok) ? fpa_pkg::ST_NO_ID : fpa_pkg::ST_DONE;
      chosen_nxt = (in_data.operation == fpa_pkg::OP_LOAD) ?
                   in_data.partition_index : 4'd0;
    end
    if (ucw.load_wr) begin
      wr_addr = req_idx9[IW-1:0];
      tbl_wr.load = (req_idx9 < 9'(PARTITIONS));
    end
    if (ucw.scan) begin
      pend_nxt = rd_en;
      if (rd_en) begin
        pend_idx_nxt = cnt_r[IW-1:0];
        cnt_nxt = cnt_r + CW'(1);
      end
      if (take) begin
        found_nxt = 1'b1;
        pick_nxt = pend_idx_r;
        best_nxt = rd_size;
      end
    end
    if (ucw.commit) begin
      if (!found_r) begin
        status_nxt = is_rel ? fpa_pkg::ST_NO_ID : fpa_pkg::ST_NO_FIT;
      end else begin
        status_nxt = fpa_pkg::ST_DONE;
        chosen_nxt = pick9[3:0];
        if (is_rel) begin
          tbl_wr.rel = 1'b1;
        end else begin
          tbl_wr.alloc = 1'b1;
          left_nxt = gap;
          frag_nxt = sum25[24] ? '1 : sum25[23:0];
        end
      end
    end
  end

  fpa_table #(.PARTITIONS(PARTITIONS)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (cnt_r[IW-1:0]),
    .rd_size  (rd_size),
    .rd_owner (rd_owner),
    .rd_busy  (rd_busy),
    .wr       (tbl_wr),
    .wr_addr  (wr_addr),
    .wr_size  (req_r.request_size),
    .wr_owner (req_r.process_id)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    pend_idx_r <= pend_idx_nxt;
    pick_r <= pick_nxt;
    best_r <= best_nxt;
    status_r <= status_nxt;
    chosen_r <= chosen_nxt;
    left_r <= left_nxt;
    if (emit_fire) begin
      out_data_r <= '{status: status_r, chosen_partition: chosen_r,
                      leftover: left_r, fragmentation_total: frag_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pend_r <= 1'b0;
      found_r <= 1'b0;
      frag_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      pend_r <= pend_nxt;
      found_r <= found_nxt;
      frag_r <= frag_nxt;
      out_valid_r <= emit_fire || (out_valid_r && !out_ready);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
`default_nettype wire

[rtl/fpa_checker.sv]
// Port-level checks for the fixed partition allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fpa_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire fpa_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != fpa_pkg::ST_DONE |->
      out_data.chosen_partition == 4'd0 && out_data.leftover == 16'd0)
    else $error("failed request reports a partition or leftover");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

endmodule

bind fixed_partition_allocator_core fpa_checker u_fpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
